[hw/rtl/bpa_pkg.sv]
`default_nettype none

package bpa_pkg;

  // Address and field widths.
  localparam int ADDR_W    = 52;
  localparam int PIP_W     = 11;
  localparam int COUNT_W   = 10;
  localparam int CFG_IDX_W = 8;

  // Stream packing.
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 64;

  // Used map is stored as words of flags.
  localparam int WORD_W    = 32;
  localparam int WORD_BITS = 5;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES     = 8'd1;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = '0;
  localparam logic [PIP_W-1:0]  PAGES_RESET     = 11'd1024;

  // Opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // latch the accepted request
    logic prep;    // pick the map row and issue its read
    logic check;   // test the row, write it back, update the count
    logic finish;  // form the result into the output register
  } bpa_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/bpa_ram.sv]
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bpa_ctrl.sv]
`default_nettype none

module bpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output bpa_pkg::bpa_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREP   = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait here until the output register can take the result.
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bpa_datapath.sv]
`default_nettype none

module bpa_datapath #(
  parameter int MAX_PAGES = 1024,
  parameter int PAGE_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bpa_pkg::bpa_cmd_t               cmd,
  input  wire logic                            req_op_in,
  input  wire logic [bpa_pkg::ADDR_W-1:0]      req_addr_in,
  input  wire logic                            cfg_we,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bpa_pkg::ADDR_W-1:0]      cfg_wdata,
  output logic                                 out_ok,
  output logic      [bpa_pkg::ADDR_W-1:0]      out_addr,
  output logic      [bpa_pkg::COUNT_W-1:0]     out_count
);

  localparam int WW    = bpa_pkg::WORD_W;
  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int AW    = bpa_pkg::ADDR_W;
  localparam int ROWS  = (MAX_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W = ROW_W + WB;
  localparam int NW    = $clog2(MAX_PAGES + 1);
  localparam int CW    = (NW > bpa_pkg::PIP_W) ? NW : bpa_pkg::PIP_W;
  localparam int CNT_W = $clog2(MAX_PAGES);
  localparam int HI_W  = AW - PAGE_BITS;
  localparam int OW    = bpa_pkg::COUNT_W;

  // Configuration.
  logic [AW-1:0]                pool_base;
  logic [bpa_pkg::PIP_W-1:0]    pages_in_pool;

  // Request and intermediate results.
  logic                         req_op;
  logic [AW-1:0]                req_addr;
  logic [ROW_W-1:0]             sel_row;
  logic [WB-1:0]                sel_bit;
  logic                         sel_bad;
  logic                         res_op;
  logic                         res_ok;
  logic [IDX_W-1:0]             res_idx;

  // Map state: a full flag and a written flag per row, count of used pages.
  logic [ROWS-1:0]              full;
  logic [ROWS-1:0]              row_valid;
  logic [CNT_W-1:0]             used_count;

  logic [WW-1:0]                rd_data;

  // Effective page count, clamped to one through MAX_PAGES.
  logic [CW-1:0]                n_eff;
  logic [CW-1:0]                pip_ext;

  always_comb begin
    pip_ext = CW'(pages_in_pool);
    if (pip_ext > CW'(MAX_PAGES)) begin
      n_eff = CW'(MAX_PAGES);
    end else if (pip_ext == '0) begin
      n_eff = CW'(1);
    end else begin
      n_eff = pip_ext;
    end
  end

  // Row pick: first row that still has a free page, or the row of the page to free.
  logic [ROW_W-1:0]             enc_row;
  logic                         enc_none;
  logic [AW-1:0]                rel;
  logic [HI_W-1:0]              rel_hi;
  logic                         free_good;
  logic [IDX_W-1:0]             free_idx;
  logic [ROW_W-1:0]             rd_row;

  always_comb begin
    enc_row  = '0;
    enc_none = &full;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!full[r]) begin
        enc_row = ROW_W'(r);
      end
    end
  end

  assign rel       = req_addr - pool_base;
  assign rel_hi    = rel[AW-1:PAGE_BITS];
  assign free_good = (rel[PAGE_BITS-1:0] == '0) && (rel_hi < HI_W'(n_eff));
  assign free_idx  = rel_hi[IDX_W-1:0];
  assign rd_row    = (req_op == bpa_pkg::OP_ALLOC) ? enc_row : free_idx[IDX_W-1:WB];

  // Row check: a row never written reads as all free. Page zero always looks used.
  logic [WW-1:0]                word;
  logic [WW-1:0]                mask0;
  logic [WW-1:0]                srch;
  logic [WB-1:0]                fbit;
  logic                         found;
  logic [IDX_W-1:0]             a_idx;
  logic                         chk_ok;
  logic [WW-1:0]                new_word;

  assign word  = row_valid[sel_row] ? rd_data : '0;
  assign mask0 = (sel_row == '0) ? WW'(1) : '0;
  assign srch  = word | mask0;

  always_comb begin
    fbit  = '0;
    found = 1'b0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (!srch[b]) begin
        fbit  = WB'(b);
        found = 1'b1;
      end
    end
  end

  assign a_idx = {sel_row, fbit};

  always_comb begin
    if (req_op == bpa_pkg::OP_ALLOC) begin
      chk_ok   = !sel_bad && found && (CW'(a_idx) < n_eff);
      new_word = word | (WW'(1) << fbit);
    end else begin
      chk_ok   = !sel_bad && word[sel_bit];
      new_word = word & ~(WW'(1) << sel_bit);
    end
  end

  bpa_ram #(
    .WIDTH (WW),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (cmd.check && chk_ok),
    .wr_addr (sel_row),
    .wr_data (new_word),
    .rd_en   (cmd.prep),
    .rd_addr (rd_row),
    .rd_data (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base     <= bpa_pkg::POOL_BASE_RESET;
      pages_in_pool <= bpa_pkg::PAGES_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == bpa_pkg::CFG_POOL_BASE) begin
        pool_base <= cfg_wdata;
      end else if (cfg_idx == bpa_pkg::CFG_PAGES) begin
        pages_in_pool <= cfg_wdata[bpa_pkg::PIP_W-1:0];
      end
    end
  end

  // Map bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      full       <= '0;
      row_valid  <= '0;
      used_count <= '0;
    end else if (cmd.check && chk_ok) begin
      row_valid[sel_row] <= 1'b1;
      full[sel_row]      <= &(new_word | mask0);
      if (req_op == bpa_pkg::OP_ALLOC) begin
        used_count <= used_count + CNT_W'(1);
      end else if (used_count != '0) begin
        used_count <= used_count - CNT_W'(1);
      end
    end
  end

  // Payload registers.
  logic [CNT_W+OW-1:0]          count_ext;

  assign count_ext = {{OW{1'b0}}, used_count};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_op   <= req_op_in;
      req_addr <= req_addr_in;
    end
    if (cmd.prep) begin
      sel_row <= rd_row;
      sel_bit <= free_idx[WB-1:0];
      sel_bad <= (req_op == bpa_pkg::OP_ALLOC) ? enc_none : !free_good;
    end
    if (cmd.check) begin
      res_op  <= req_op;
      res_ok  <= chk_ok;
      res_idx <= a_idx;
    end
    if (cmd.finish) begin
      out_ok    <= res_ok;
      out_count <= count_ext[OW-1:0];
      if (res_ok && (res_op == bpa_pkg::OP_ALLOC)) begin
        out_addr <= pool_base + (AW'(res_idx) << PAGE_BITS);
      end else begin
        out_addr <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bitmap_page_allocator.sv]
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  tdata: free_address; tuser: opcode
// m_       out        m_tvalid / m_tready  tdata: ok, page_address, pages_in_use
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The request is latched at its accepting edge; then the row pick and RAM read, the
// row read-modify-write and the result load follow in turn (PREP, CHECK, FINISH). No
// new item is taken until the last result is loaded; the steps are paced by the
// registered read of the used-map word. Reset empties the map at once through
// per-row written flags, with no clearing pass. A waiting result stalls the next
// item only at its last step, and configuration writes are always taken.
`default_nettype none

module bitmap_page_allocator #(
  parameter int MAX_PAGES = 1024,
  parameter int PAGE_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,

  // Request items.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [51:0] free_address, [55:52] zero.
  input  wire logic [bpa_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] opcode.
  input  wire logic [bpa_pkg::S_TUSER_W-1:0]   s_tuser,

  // Result items.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] ok, [52:1] page_address, [62:53] pages_in_use, [63] zero.
  output logic      [bpa_pkg::M_TDATA_W-1:0]   m_tdata,

  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bpa_pkg::ADDR_W-1:0]      cfg_data
);

  bpa_pkg::bpa_cmd_t               cmd;
  logic                            res_ok;
  logic [bpa_pkg::ADDR_W-1:0]      res_addr;
  logic [bpa_pkg::COUNT_W-1:0]     res_count;

  // Registers live in flip-flops and can take a write on any cycle.
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_op_in   (s_tuser[0]),
    .req_addr_in (s_tdata[bpa_pkg::ADDR_W-1:0]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .out_ok      (res_ok),
    .out_addr    (res_addr),
    .out_count   (res_count)
  );

  assign m_tdata = {1'b0, res_count, res_addr, res_ok};

`ifndef SYNTHESIS
  // Only one item is in flight: acceptance closes the input until the result forms.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  // A failed operation never reports a page address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[52:1] == '0)
    else $error("failed result carries a page address");

  // A new result appears only as the controller returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result loaded outside the finish step");
`endif

endmodule

`default_nettype wire
